// ===== hw/rtl/tgse_pkg.sv =====
`timescale 1ns / 1ps

package tgse_pkg;

  // Sheet geometry: 4-bit pixels, two to a byte, 8x8 tiles in Z order.
  localparam int SHEET_WIDTH  = 128;
  localparam int SHEET_HEIGHT = 32;
  localparam int CROP_WIDTH   = 25;
  localparam int CROP_HEIGHT  = 32;
  localparam int MAX_OUT      = 13;

  localparam int STORE_DEPTH  = (SHEET_WIDTH * SHEET_HEIGHT) / 2;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int COL_BITS     = $clog2(SHEET_WIDTH / 8);
  localparam int ROW_BITS     = $clog2(SHEET_HEIGHT / 8);

  localparam int ROW_PIXELS   = (CROP_WIDTH + 1) / 2;
  localparam int OUT_COUNT    = (ROW_PIXELS > MAX_OUT) ? MAX_OUT : ROW_PIXELS;
  localparam int K_W          = $clog2(OUT_COUNT);
  localparam int GX_W         = K_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN
  } state_t;

  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_EXTRACT = 1'b1
  } action_t;

  localparam logic REG_DATA_WIDTH  = 1'b0;
  localparam logic REG_DATA_HEIGHT = 1'b1;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// ===== hw/rtl/tiled_glyph_sheet_extract_shrink_unit.sv =====
`timescale 1ns / 1ps

// Glyph sheet detiler and 2x2 shrinker. A load item writes one byte of the
// tiled 4-bit sheet and produces nothing. An extract item reads four sheet
// pixels for each of the 13 output pixels through the one read port of the
// sheet memory, one read per cycle while the output side does not stall;
// after the last read a drain state waits for its data before the last pixel
// is presented. Pixels leave through an output register, and the next read
// waits only when a finished pixel cannot yet be placed there. Columns at or
// beyond data_width and rows at or beyond data_height read as zero.
module tiled_glyph_sheet_extract_shrink_unit
  import tgse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [10:0] in_sheet_addr,
  input  logic [7:0]  in_sheet_byte,
  input  logic [2:0]  in_glyph_slot,
  input  logic [3:0]  in_out_row,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pixel,
  output logic        out_last
);

  localparam logic [K_W-1:0] LAST_K = K_W'(OUT_COUNT - 1);

  state_t state_r, state_nxt;

  logic [7:0]      data_width_r;
  logic [5:0]      data_height_r;

  logic [K_W-1:0]  k_r, k_nxt;
  logic [1:0]      ph_r, ph_nxt;
  logic [7:0]      base_r, base_nxt;
  logic [3:0]      row_r, row_nxt;
  logic [9:0]      acc_r, acc_nxt;

  logic            dv_r, dv_nxt;
  logic            tlast_r, tlast_nxt;
  logic            zero_r, zero_nxt;
  logic            hi_r, hi_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_pixel_r, out_pixel_nxt;
  logic            out_last_r, out_last_nxt;

  logic            out_free, stall, fire, issue, accept;
  logic [GX_W-1:0] xi_odd, gx;
  logic [5:0]      gy;
  logic [8:0]      sx;
  logic            at_edge, force_zero, rd_zero;
  logic [ADDR_W-1:0] rd_addr;
  logic [3:0]      nib;
  logic [7:0]      term;
  logic [9:0]      sum;
  logic [7:0]      rdata;
  ram_req_t        ram_req;

  assign out_free = !out_valid_r || out_ready;
  assign stall    = dv_r && tlast_r && !out_free;
  assign fire     = dv_r && tlast_r && out_free;
  assign issue    = (state_r == ST_READ) && !stall;
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Sheet coordinate of the read for term ph_r of output pixel k_r.
  // On an odd-width glyph the last pixel's right column wraps to column 0
  // of the next row, and its bottom-right term is zero.
  always_comb begin
    xi_odd     = {k_r, 1'b1};
    at_edge    = (xi_odd == GX_W'(CROP_WIDTH));
    force_zero = 1'b0;
    gx         = {k_r, 1'b0};
    gy         = {1'b0, row_r, 1'b0};
    case (ph_r)
      2'd0: begin
        gx = {k_r, 1'b0};
        gy = {1'b0, row_r, 1'b0};
      end
      2'd1: begin
        gx = {k_r, 1'b0};
        gy = {1'b0, row_r, 1'b1};
      end
      2'd2: begin
        gx = at_edge ? '0 : xi_odd;
        gy = at_edge ? {1'b0, row_r, 1'b1} : {1'b0, row_r, 1'b0};
      end
      default: begin
        gx         = xi_odd;
        gy         = {1'b0, row_r, 1'b1};
        force_zero = at_edge;
      end
    endcase
    sx      = 9'(base_r) + 9'(gx);
    rd_zero = force_zero
           || (sx >= {1'b0, data_width_r})
           || (sx >= 9'(SHEET_WIDTH))
           || (gy >= data_height_r)
           || (gy >= 6'(SHEET_HEIGHT))
           || (gy >= 6'(CROP_HEIGHT));
    rd_addr = {gy[ROW_BITS+2:3], sx[COL_BITS+2:3], gy[2], sx[2], gy[1], sx[1], gy[0]};
  end

  always_comb begin
    nib  = hi_r ? rdata[7:4] : rdata[3:0];
    term = zero_r ? 8'd0 : {nib, nib};
    sum  = acc_r + 10'(term);
  end

  always_comb begin
    ram_req.we    = accept && (in_action == ACT_LOAD);
    ram_req.waddr = in_sheet_addr;
    ram_req.wdata = in_sheet_byte;
    ram_req.re    = issue;
    ram_req.raddr = rd_addr;
  end

  tgse_sheet_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_action == ACT_EXTRACT)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (issue && (ph_r == 2'd3) && (k_r == LAST_K)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer and datapath.
  always_comb begin
    k_nxt         = k_r;
    ph_nxt        = ph_r;
    base_nxt      = base_r;
    row_nxt       = row_r;
    acc_nxt       = acc_r;
    tlast_nxt     = tlast_r;
    zero_nxt      = zero_r;
    hi_nxt        = hi_r;
    out_valid_nxt = out_valid_r;
    out_pixel_nxt = out_pixel_r;
    out_last_nxt  = out_last_r;

    if (accept && (in_action == ACT_EXTRACT)) begin
      k_nxt    = '0;
      ph_nxt   = 2'd0;
      base_nxt = 8'(in_glyph_slot) * 8'(CROP_WIDTH);
      row_nxt  = in_out_row;
      acc_nxt  = '0;
    end

    if (issue) begin
      ph_nxt    = ph_r + 2'd1;
      tlast_nxt = (ph_r == 2'd3);
      zero_nxt  = rd_zero;
      hi_nxt    = sx[0];
      if (ph_r == 2'd3) begin
        k_nxt = k_r + K_W'(1);
      end
    end

    if (dv_r && !stall) begin
      acc_nxt = tlast_r ? '0 : sum;
    end

    if (fire) begin
      out_valid_nxt = 1'b1;
      out_pixel_nxt = sum[9:2];
      out_last_nxt  = (state_r == ST_DRAIN);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    dv_nxt = stall ? dv_r : issue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      dv_r          <= 1'b0;
      out_valid_r   <= 1'b0;
      data_width_r  <= 8'd128;
      data_height_r <= 6'd32;
    end else begin
      state_r     <= state_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DATA_WIDTH:  data_width_r  <= cfg_data;
          REG_DATA_HEIGHT: data_height_r <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    ph_r        <= ph_nxt;
    base_r      <= base_nxt;
    row_r       <= row_nxt;
    acc_r       <= acc_nxt;
    tlast_r     <= tlast_nxt;
    zero_r      <= zero_nxt;
    hi_r        <= hi_nxt;
    out_pixel_r <= out_pixel_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_last  = out_last_r;

endmodule

// ===== hw/rtl/tgse_sheet_ram.sv =====
`timescale 1ns / 1ps

module tgse_sheet_ram
  import tgse_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output logic [7:0] rdata
);

  logic [7:0] mem_r [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem_r[req.raddr];
    end
  end

endmodule
